>>> rtl/core/archive_hash_table_lookup_unit_defines.svh
// Assertion macros shared by the lookup unit RTL.
// No dependencies; include after the timescale line of a file that asserts.
`ifndef ARCHIVE_HASH_TABLE_LOOKUP_UNIT_DEFINES_SVH
`define ARCHIVE_HASH_TABLE_LOOKUP_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define AHT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define AHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/aht_pkg.sv
// Shared types and constants of the archive hash table lookup unit.
// No dependencies; compile first.
`timescale 1ns / 1ps

package aht_pkg;

    localparam int HASH_DEPTH_DEF  = 4096;
    localparam int BLOCK_DEPTH_DEF = 4096;

    localparam int OP_W      = 2;
    localparam int IDX_W     = 12;
    localparam int WORD_W    = 32;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int STATUS_W  = 3;
    localparam int EXISTS_BIT = 31;

    localparam logic [WORD_W-1:0] LINK_FREE    = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] LINK_DELETED = 32'hFFFF_FFFE;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ARCHIVE_OPEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT  = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP   = 2'd0,
        OP_WR_HASH  = 2'd1,
        OP_WR_BLOCK = 2'd2,
        OP_UNUSED   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND        = 3'd0,
        ST_NOT_FOUND    = 3'd1,
        ST_CLOSED       = 3'd2,
        ST_BAD_BLOCK    = 3'd3,
        ST_NOT_EXISTING = 3'd4,
        ST_WRITTEN      = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_PROBE = 2'd1,
        S_BLOCK = 2'd2,
        S_FIN   = 2'd3
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    typedef struct packed {
        logic              valid;
        t_status           status;
        logic [IDX_W-1:0]  block;
    } t_result;

endpackage

>>> rtl/core/archive_hash_table_lookup_unit.sv
// Archive hash table lookup unit: top level with config registers and result register.
// Depends on aht_pkg, aht_ram and aht_probe_ctrl.
`timescale 1ns / 1ps

// Each request on the slave stream is a table write or a lookup, chosen by
// s_axis_tuser. A hash write stores two name hashes and a block link, a block
// write stores position, sizes and flags; both answer "written" (status 5),
// and writes at an index beyond the table depth are dropped. A lookup walks
// the hash table from probe_hash masked by hash_count - 1, one entry per
// cycle out of the hash memory's single read port: a free link ends the walk,
// a deleted link is skipped, and at most hash_count entries are visited. On a
// match of both name hashes the link is range checked and the block entry is
// read to test its exists bit (flag bit 31). One request is in flight at a
// time; the next request is taken as soon as the previous result sits in the
// output register, even while the master side stalls. Table entries have no
// reset and must be written before a lookup touches them; no clearing pass
// runs after reset. Program archive_open, hash_count and block_count only
// while no request is in flight.
module archive_hash_table_lookup_unit #(
    parameter int HASH_DEPTH  = aht_pkg::HASH_DEPTH_DEF,
    parameter int BLOCK_DEPTH = aht_pkg::BLOCK_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [aht_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [aht_pkg::CFG_W-1:0]         i_cfg_data,
    // request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata, low bit up: table_index[11:0], probe_hash[43:12], name_hash_a[75:44],
    // name_hash_b[107:76], entry_block_ref[139:108], file_position[171:140],
    // packed_bytes[203:172], unpacked_bytes[235:204], flag_word[267:236], zero pad
    input  logic [271:0]                      s_axis_tdata,
    // tuser: operation[1:0]
    input  logic [aht_pkg::OP_W-1:0]          s_axis_tuser,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata, low bit up: status[2:0], found_block[14:3], found_position[46:15],
    // found_packed[78:47], found_unpacked[110:79], found_flags[142:111], zero pad
    output logic [143:0]                      m_axis_tdata
);
    import aht_pkg::*;

    localparam int HAW = (HASH_DEPTH > 1) ? $clog2(HASH_DEPTH) : 1;
    localparam int BAW = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;

    // configuration registers
    logic               r_archive_open;
    logic [CFG_W-1:0]   r_hash_count;
    logic [CFG_W-1:0]   r_block_count;

    // result register
    logic               r_o_valid;
    t_status            r_status;
    logic [IDX_W-1:0]   r_found_block;
    logic [WORD_W-1:0]  r_found_position, r_found_packed, r_found_unpacked, r_found_flags;

    logic               req_accept, slot_free;
    t_result            result;
    t_mem_ctl           hash_ctl, block_ctl;
    logic [HAW-1:0]     hash_wr_addr, hash_rd_addr;
    logic [BAW-1:0]     block_wr_addr, block_rd_addr;
    logic [3*WORD_W-1:0] hash_wr_data, hash_rd_data;
    logic [4*WORD_W-1:0] block_wr_data, block_rd_data;
    logic               ctrl_ready;

    assign s_axis_tready = ctrl_ready;
    assign req_accept    = s_axis_tvalid && ctrl_ready;
    // the result register frees up when empty or when its result leaves now
    assign slot_free     = !r_o_valid || m_axis_tready;

    // hash entry: first hash low, then second hash, then block link
    assign hash_wr_data  = {s_axis_tdata[139:108], s_axis_tdata[107:76], s_axis_tdata[75:44]};
    // block entry: position low, then packed, unpacked, flags
    assign block_wr_data = {s_axis_tdata[267:236], s_axis_tdata[235:204],
                            s_axis_tdata[203:172], s_axis_tdata[171:140]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_archive_open <= 1'b0;
            r_hash_count   <= '0;
            r_block_count  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ARCHIVE_OPEN: r_archive_open <= i_cfg_data[0];
                CFG_HASH_COUNT:   r_hash_count   <= i_cfg_data;
                CFG_BLOCK_COUNT:  r_block_count  <= i_cfg_data;
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    aht_ram #(
        .DEPTH (HASH_DEPTH),
        .WIDTH (3 * WORD_W),
        .AW    (HAW)
    ) u_hash_ram (
        .i_clk     (i_clk),
        .i_ctl     (hash_ctl),
        .i_wr_addr (hash_wr_addr),
        .i_wr_data (hash_wr_data),
        .i_rd_addr (hash_rd_addr),
        .o_rd_data (hash_rd_data)
    );

    aht_ram #(
        .DEPTH (BLOCK_DEPTH),
        .WIDTH (4 * WORD_W),
        .AW    (BAW)
    ) u_block_ram (
        .i_clk     (i_clk),
        .i_ctl     (block_ctl),
        .i_wr_addr (block_wr_addr),
        .i_wr_data (block_wr_data),
        .i_rd_addr (block_rd_addr),
        .o_rd_data (block_rd_data)
    );

    aht_probe_ctrl #(
        .HASH_DEPTH  (HASH_DEPTH),
        .BLOCK_DEPTH (BLOCK_DEPTH),
        .HAW         (HAW),
        .BAW         (BAW)
    ) u_probe_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (req_accept),
        .i_op            (t_op'(s_axis_tuser)),
        .i_table_index   (s_axis_tdata[11:0]),
        .i_probe_hash    (s_axis_tdata[43:12]),
        .i_name_hash_a   (s_axis_tdata[75:44]),
        .i_name_hash_b   (s_axis_tdata[107:76]),
        .i_archive_open  (r_archive_open),
        .i_hash_count    (r_hash_count),
        .i_block_count   (r_block_count),
        .i_hash_rd_data  (hash_rd_data),
        .i_block_flags   (block_rd_data[4*WORD_W-1:3*WORD_W]),
        .i_slot_free     (slot_free),
        .o_ready         (ctrl_ready),
        .o_result        (result),
        .o_hash_ctl      (hash_ctl),
        .o_hash_wr_addr  (hash_wr_addr),
        .o_hash_rd_addr  (hash_rd_addr),
        .o_block_ctl     (block_ctl),
        .o_block_wr_addr (block_wr_addr),
        .o_block_rd_addr (block_rd_addr)
    );

    // result register valid: load on a finished request, clear when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (result.valid && slot_free) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    // result payload: block fields only on a hit, zero otherwise.
    // The block read data still holds the matched entry while the result waits.
    always_ff @(posedge i_clk) begin
        if (result.valid && slot_free) begin
            r_status <= result.status;
            if (result.status == ST_FOUND) begin
                r_found_block    <= result.block;
                r_found_position <= block_rd_data[WORD_W-1:0];
                r_found_packed   <= block_rd_data[2*WORD_W-1:WORD_W];
                r_found_unpacked <= block_rd_data[3*WORD_W-1:2*WORD_W];
                r_found_flags    <= block_rd_data[4*WORD_W-1:3*WORD_W];
            end else begin
                r_found_block    <= '0;
                r_found_position <= '0;
                r_found_packed   <= '0;
                r_found_unpacked <= '0;
                r_found_flags    <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {1'b0, r_found_flags, r_found_unpacked, r_found_packed,
                            r_found_position, r_found_block, r_status};

endmodule

>>> rtl/core/aht_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies beyond the package for its types.
`timescale 1ns / 1ps

module aht_ram #(
    parameter int DEPTH = aht_pkg::HASH_DEPTH_DEF,
    parameter int WIDTH = aht_pkg::WORD_W,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                i_clk,
    input  aht_pkg::t_mem_ctl   i_ctl,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic [WIDTH-1:0]    i_wr_data,
    input  logic [AW-1:0]       i_rd_addr,
    output logic [WIDTH-1:0]    o_rd_data
);
    import aht_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/aht_probe_ctrl.sv
// Request sequencer: table writes, linear probe walk and block fetch.
// Depends on aht_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "archive_hash_table_lookup_unit_defines.svh"

module aht_probe_ctrl #(
    parameter int HASH_DEPTH  = aht_pkg::HASH_DEPTH_DEF,
    parameter int BLOCK_DEPTH = aht_pkg::BLOCK_DEPTH_DEF,
    parameter int HAW = (HASH_DEPTH > 1) ? $clog2(HASH_DEPTH) : 1,
    parameter int BAW = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    input  aht_pkg::t_op                     i_op,
    input  logic [aht_pkg::IDX_W-1:0]        i_table_index,
    input  logic [aht_pkg::WORD_W-1:0]       i_probe_hash,
    input  logic [aht_pkg::WORD_W-1:0]       i_name_hash_a,
    input  logic [aht_pkg::WORD_W-1:0]       i_name_hash_b,
    input  logic                             i_archive_open,
    input  logic [aht_pkg::CFG_W-1:0]        i_hash_count,
    input  logic [aht_pkg::CFG_W-1:0]        i_block_count,
    input  logic [3*aht_pkg::WORD_W-1:0]     i_hash_rd_data,
    input  logic [aht_pkg::WORD_W-1:0]       i_block_flags,
    input  logic                             i_slot_free,
    output logic                             o_ready,
    output aht_pkg::t_result                 o_result,
    output aht_pkg::t_mem_ctl                o_hash_ctl,
    output logic [HAW-1:0]                   o_hash_wr_addr,
    output logic [HAW-1:0]                   o_hash_rd_addr,
    output aht_pkg::t_mem_ctl                o_block_ctl,
    output logic [BAW-1:0]                   o_block_wr_addr,
    output logic [BAW-1:0]                   o_block_rd_addr
);
    import aht_pkg::*;

    localparam int HCW  = $clog2(HASH_DEPTH + 1);
    localparam int NW   = (HCW > CFG_W) ? HCW : CFG_W;
    localparam int HIXW = ((HAW > IDX_W) ? HAW : IDX_W) + 1;
    localparam int BIXW = ((BAW > IDX_W) ? BAW : IDX_W) + 1;

    t_state             r_state, n_state;
    logic [HAW-1:0]     r_idx, n_idx;
    logic [HAW-1:0]     r_mask, n_mask;
    logic [NW-1:0]      r_tries, n_tries;
    logic [NW-1:0]      r_cnt, n_cnt;
    logic [WORD_W-1:0]  r_ha, n_ha;
    logic [WORD_W-1:0]  r_hb, n_hb;
    t_status            r_status, n_status;
    logic [IDX_W-1:0]   r_block, n_block;

    logic [NW-1:0]      cnt_cfg, mask_cfg, tries_nx;
    logic [HAW-1:0]     idx0, idx_nx;
    logic [HIXW-1:0]    hash_idx_ext;
    logic [BIXW-1:0]    block_idx_ext;
    logic               closed, start_probe, take;
    logic [WORD_W-1:0]  ent_first, ent_second, ent_link;
    logic               is_free, is_hit, is_bad, go_on;

    assign cnt_cfg  = (NW'(i_hash_count) > NW'(HASH_DEPTH)) ? NW'(HASH_DEPTH)
                                                           : NW'(i_hash_count);
    assign mask_cfg = cnt_cfg - NW'(1);
    assign idx0     = i_probe_hash[HAW-1:0] & mask_cfg[HAW-1:0];
    assign closed   = !i_archive_open || (i_hash_count == '0);
    assign start_probe = i_req_valid && (i_op == OP_LOOKUP) && !closed;

    assign hash_idx_ext  = HIXW'(i_table_index);
    assign block_idx_ext = BIXW'(i_table_index);

    assign ent_first  = i_hash_rd_data[WORD_W-1:0];
    assign ent_second = i_hash_rd_data[2*WORD_W-1:WORD_W];
    assign ent_link   = i_hash_rd_data[3*WORD_W-1:2*WORD_W];

    assign is_free  = (ent_link == LINK_FREE);
    assign is_hit   = !is_free && (ent_link != LINK_DELETED)
                      && (ent_first == r_ha) && (ent_second == r_hb);
    assign is_bad   = (ent_link >= WORD_W'(i_block_count))
                      || (ent_link >= WORD_W'(BLOCK_DEPTH));
    assign tries_nx = r_tries + NW'(1);
    assign go_on    = !is_free && !is_hit && (tries_nx < r_cnt);
    assign idx_nx   = (r_idx + HAW'(1)) & r_mask;
    assign take     = (r_state == S_FIN) && i_slot_free;

    // next state and working registers
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_mask   = r_mask;
        n_tries  = r_tries;
        n_cnt    = r_cnt;
        n_ha     = r_ha;
        n_hb     = r_hb;
        n_status = r_status;
        n_block  = r_block;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_ha    = i_name_hash_a;
                    n_hb    = i_name_hash_b;
                    n_cnt   = cnt_cfg;
                    n_mask  = mask_cfg[HAW-1:0];
                    n_idx   = idx0;
                    n_tries = '0;
                    if (start_probe) begin
                        n_state = S_PROBE;
                    end else begin
                        n_status = (i_op == OP_LOOKUP) ? ST_CLOSED : ST_WRITTEN;
                        n_state  = S_FIN;
                    end
                end
            end
            S_PROBE: begin
                if (is_free) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_FIN;
                end else if (is_hit) begin
                    n_block = ent_link[IDX_W-1:0];
                    if (is_bad) begin
                        n_status = ST_BAD_BLOCK;
                        n_state  = S_FIN;
                    end else begin
                        n_state = S_BLOCK;
                    end
                end else if (go_on) begin
                    n_idx   = idx_nx;
                    n_tries = tries_nx;
                end else begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_FIN;
                end
            end
            S_BLOCK: begin
                n_status = i_block_flags[EXISTS_BIT] ? ST_FOUND : ST_NOT_EXISTING;
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memory ports and handshake
    always_comb begin
        o_ready           = (r_state == S_IDLE);
        o_result.valid    = (r_state == S_FIN);
        o_result.status   = r_status;
        o_result.block    = r_block;
        o_hash_wr_addr    = hash_idx_ext[HAW-1:0];
        o_block_wr_addr   = block_idx_ext[BAW-1:0];
        o_hash_rd_addr    = (r_state == S_IDLE) ? idx0 : idx_nx;
        o_block_rd_addr   = ent_link[BAW-1:0];
        o_hash_ctl.wr_en  = (r_state == S_IDLE) && i_req_valid && (i_op == OP_WR_HASH)
                            && (hash_idx_ext < HIXW'(HASH_DEPTH));
        o_block_ctl.wr_en = (r_state == S_IDLE) && i_req_valid && (i_op == OP_WR_BLOCK)
                            && (block_idx_ext < BIXW'(BLOCK_DEPTH));
        o_hash_ctl.rd_en  = ((r_state == S_IDLE) && start_probe)
                            || ((r_state == S_PROBE) && go_on);
        o_block_ctl.rd_en = (r_state == S_PROBE) && is_hit && !is_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_mask   <= n_mask;
        r_tries  <= n_tries;
        r_cnt    <= n_cnt;
        r_ha     <= n_ha;
        r_hb     <= n_hb;
        r_status <= n_status;
        r_block  <= n_block;
    end

    `AHT_ASSERT_NOW(a_no_write_busy, i_clk, i_rst_n, r_state != S_IDLE, !o_hash_ctl.wr_en && !o_block_ctl.wr_en, "table write while a request is in flight")
    `AHT_ASSERT_NOW(a_probe_bound, i_clk, i_rst_n, r_state == S_PROBE, r_tries < r_cnt, "probe walk ran past the hash count")
    `AHT_ASSERT_NEXT(a_hash_read_probe, i_clk, i_rst_n, o_hash_ctl.rd_en, r_state == S_PROBE, "hash read not followed by a probe check")
    `AHT_ASSERT_NEXT(a_block_read_check, i_clk, i_rst_n, o_block_ctl.rd_en, r_state == S_BLOCK, "block read not followed by a block check")

endmodule
